// ===== hw/rtl/mtrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrl_pkg
// Shared types, sizes and helpers of the multibit trie route lookup block.
// ----------------------------------------------------------------------------
package mtrl_pkg;

	localparam int ADDR_BITS  = 32;
	localparam int WIDE_BITS  = 64;
	localparam int STRIDE     = 4;
	localparam int FANOUT     = 1 << STRIDE;
	localparam int POOL_NODES = 4096;
	localparam int HOP_BITS   = 16;
	localparam int LEN_W      = 6;
	localparam int HOP_W      = 16;
	localparam int NODE_W     = $clog2(POOL_NODES);
	localparam int LINK_W     = $clog2(POOL_NODES + 1);
	localparam int CHILD_AW   = NODE_W + STRIDE;
	localparam int LEVELS     = (ADDR_BITS + STRIDE - 1) / STRIDE + 1;
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int DEPTH_W    = $clog2(WIDE_BITS + STRIDE);
	localparam int TOT_W      = DEPTH_W + 1;
	localparam int IDX_W      = STRIDE + 1;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;
	localparam logic ST_DONE     = 1'b0;
	localparam logic ST_FULL     = 1'b1;

	// How a frame of the insert walk visits the children of its node.
	localparam logic [1:0] MODE_ALL  = 2'd0;
	localparam logic [1:0] MODE_EXP  = 2'd1;
	localparam logic [1:0] MODE_DESC = 2'd2;

	typedef struct packed {
		logic                 func;
		logic [ADDR_BITS-1:0] dest_addr;
		logic [LEN_W-1:0]     prefix_len;
		logic [HOP_W-1:0]     next_hop_in;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [HOP_W-1:0] next_hop_out;
		logic [LEN_W-1:0] match_len;
		logic             status;
	} rsp_t;

	typedef struct packed {
		logic                lf;
		logic [LEN_W-1:0]    len;
		logic [HOP_BITS-1:0] hop;
	} leaf_t;

	typedef struct packed {
		logic [NODE_W-1:0]   node;
		logic [LEN_W-1:0]    plen;
		logic [HOP_BITS-1:0] hop;
		logic [IDX_W-1:0]    i;
		logic [1:0]          mode;
		logic                existed;
		leaf_t               leaf;
	} frame_t;

	// STRIDE address bits starting at trie bit depth; bits past the address read as zero.
	function automatic logic [STRIDE-1:0] take_stride(input logic [ADDR_BITS-1:0] addr,
			input logic [DEPTH_W-1:0] depth);
		logic [WIDE_BITS-1:0] wide;
		logic [WIDE_BITS-1:0] sh;
		logic [TOT_W-1:0]     total;
		wide  = {addr, {ADDR_BITS{1'b0}}};
		total = TOT_W'(depth) + TOT_W'(STRIDE);
		if (total > TOT_W'(WIDE_BITS)) begin
			return '0;
		end
		sh = wide >> (TOT_W'(WIDE_BITS) - total);
		return sh[STRIDE-1:0];
	endfunction

endpackage

// ===== hw/rtl/multibit_trie_route_lookup_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibit_trie_route_lookup_top
// IPv4 longest prefix match over a fixed-stride multibit trie held in RAM.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req carries either an add (route address,
// prefix length, next hop) or a lookup (address). Each request gives exactly
// one response transaction on rsp. Requests are taken one at a time; req_stall
// is high from the cycle after acceptance until its response is registered.
// A lookup reads one trie node per level from the node and child RAMs until
// it meets an empty child link or the depth limit of the walk.
// An add walks the trie as a depth-first recursion with an explicit frame
// stack. Each new node has its FANOUT child links cleared one at a time
// through the single write port of the child RAM.
// After reset the table is empty and the node pool is unused; no clearing
// pass is needed because a node is written in full when it is allocated.
// When the receiver stalls, the response is held in the output register and
// one further request may be accepted and worked on; its response then waits.
// ----------------------------------------------------------------------------
module multibit_trie_route_lookup_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  mtrl_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output mtrl_pkg::rsp_t  rsp
);

	import mtrl_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CALL     = 4'd1;
	localparam logic [3:0] S_CLR      = 4'd2;
	localparam logic [3:0] S_NODE_RD  = 4'd3;
	localparam logic [3:0] S_EVAL     = 4'd4;
	localparam logic [3:0] S_LOOP     = 4'd5;
	localparam logic [3:0] S_CHILD_RD = 4'd6;
	localparam logic [3:0] S_RET      = 4'd7;
	localparam logic [3:0] S_LK       = 4'd8;
	localparam logic [3:0] S_LK_RD    = 4'd9;
	localparam logic [3:0] S_OUT      = 4'd10;

	// Control state.
	logic [3:0]        state_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [STRIDE-1:0] clr_q;
	logic              root_q;
	logic [LINK_W-1:0] pool_q;
	logic              rsp_valid_q;

	// Walk context and results.
	frame_t              stk_q [LEVELS];
	logic [ADDR_BITS-1:0] addr_q;
	logic [LINK_W-1:0]   call_link_q;
	logic [CHILD_AW-1:0] pslot_q;
	logic [LINK_W-1:0]   lk_link_q;
	logic [DEPTH_W-1:0]  lk_depth_q;
	logic                hit_q;
	logic [HOP_BITS-1:0] hhop_q;
	logic [LEN_W-1:0]    hlen_q;
	rsp_t                res_q;
	rsp_t                rsp_q;

	// RAM ports.
	logic                n_we, n_re;
	logic [NODE_W-1:0]   n_waddr, n_raddr;
	leaf_t               n_wdata, n_rdata;
	logic                c_we, c_re;
	logic [CHILD_AW-1:0] c_waddr, c_raddr;
	logic [LINK_W-1:0]   c_wdata, c_rdata;

	// Decode of the current frame.
	frame_t              cur;
	logic [DEPTH_W-1:0]  depth;
	logic [DEPTH_W-1:0]  plen_ext;
	logic [STRIDE-1:0]   idx_add;
	logic [STRIDE-1:0]   idx_lk;
	logic [DEPTH_W-1:0]  lowsh;
	logic                in_range;
	logic                at_end;
	logic                visit;
	logic [LEN_W-1:0]    arg_plen;
	logic [HOP_BITS-1:0] arg_hop;
	logic                alloc_ok;
	logic                accept;
	logic                lk_stop;
	logic [NODE_W-1:0]   lk_node;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign cur      = stk_q[lvl_q];
	assign depth    = DEPTH_W'(lvl_q * STRIDE);
	assign plen_ext = DEPTH_W'(cur.plen);
	assign idx_add  = take_stride(addr_q, depth);
	assign idx_lk   = take_stride(addr_q, lk_depth_q);
	assign lowsh    = DEPTH_W'(depth + DEPTH_W'(STRIDE) - plen_ext);
	assign in_range = ((cur.i[STRIDE-1:0] >> lowsh) == (idx_add >> lowsh));
	assign at_end   = (cur.i == IDX_W'(FANOUT));
	assign alloc_ok = (pool_q != LINK_W'(POOL_NODES));
	assign lk_stop  = (lk_link_q == '0) || (lk_depth_q >= DEPTH_W'(WIDE_BITS));
	assign lk_node  = NODE_W'(lk_link_q - 1'b1);

	// Which child the current frame visits next, and with which route.
	// Outside the expanded range a leaf pushes its own route down.
	always_comb begin
		visit    = 1'b0;
		arg_plen = cur.plen;
		arg_hop  = cur.hop;
		case (cur.mode)
			MODE_ALL: begin
				visit = 1'b1;
			end
			MODE_EXP: begin
				if (in_range) begin
					visit = 1'b1;
				end else if (cur.leaf.lf) begin
					visit    = 1'b1;
					arg_plen = cur.leaf.len;
					arg_hop  = cur.leaf.hop;
				end
			end
			MODE_DESC: begin
				visit = 1'b1;
			end
			default: begin
				visit = 1'b0;
			end
		endcase
		if (at_end || lvl_q == LVL_W'(LEVELS - 1)) begin
			visit = 1'b0;
		end
	end

	always_comb begin
		n_we    = 1'b0;
		n_waddr = cur.node;
		n_wdata = '0;
		n_re    = 1'b0;
		n_raddr = NODE_W'(call_link_q - 1'b1);
		c_we    = 1'b0;
		c_waddr = pslot_q;
		c_wdata = '0;
		c_re    = 1'b0;
		c_raddr = {cur.node, cur.i[STRIDE-1:0]};
		case (state_q)
			S_CALL: begin
				if (call_link_q != '0) begin
					n_re = 1'b1;
				end else if (alloc_ok) begin
					// Fresh node: clear its leaf and link it into its parent.
					n_we    = 1'b1;
					n_waddr = pool_q[NODE_W-1:0];
					c_we    = (lvl_q != '0);
					c_wdata = LINK_W'(pool_q + 1'b1);
				end
			end
			S_CLR: begin
				c_we    = 1'b1;
				c_waddr = {cur.node, clr_q};
			end
			S_EVAL: begin
				if (plen_ext <= depth && !(!cur.leaf.lf && cur.existed)) begin
					n_we    = !cur.leaf.lf || (cur.plen > cur.leaf.len);
					n_wdata = '{lf: 1'b1, len: cur.plen, hop: cur.hop};
				end
			end
			S_LOOP: begin
				n_we = at_end && (cur.mode == MODE_EXP);
				c_re = visit;
			end
			S_LK: begin
				n_re    = !lk_stop;
				n_raddr = lk_node;
				c_re    = !lk_stop;
				c_raddr = {lk_node, idx_lk};
			end
			default: begin
				n_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lvl_q       <= '0;
			clr_q       <= '0;
			root_q      <= 1'b0;
			pool_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The output state loads the register itself, so it is left out here.
			if (rsp_valid_q && !rsp_stall && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q <= req.dest_addr;
						res_q  <= '0;
						if (req.func == FUNC_ADD) begin
							stk_q[0].plen <= (req.prefix_len > LEN_W'(ADDR_BITS)) ?
								LEN_W'(ADDR_BITS) : req.prefix_len;
							stk_q[0].hop  <= HOP_BITS'(req.next_hop_in);
							call_link_q   <= LINK_W'(root_q);
							lvl_q         <= '0;
							state_q       <= S_CALL;
						end else begin
							lk_link_q  <= LINK_W'(root_q);
							lk_depth_q <= '0;
							hit_q      <= 1'b0;
							hhop_q     <= '0;
							hlen_q     <= '0;
							state_q    <= S_LK;
						end
					end
				end
				S_CALL: begin
					if (call_link_q != '0) begin
						stk_q[lvl_q].node    <= NODE_W'(call_link_q - 1'b1);
						stk_q[lvl_q].existed <= 1'b1;
						state_q              <= S_NODE_RD;
					end else if (alloc_ok) begin
						stk_q[lvl_q].node    <= pool_q[NODE_W-1:0];
						stk_q[lvl_q].existed <= 1'b0;
						stk_q[lvl_q].leaf    <= '0;
						pool_q               <= LINK_W'(pool_q + 1'b1);
						if (lvl_q == '0) begin
							root_q <= 1'b1;
						end
						clr_q   <= '0;
						state_q <= S_CLR;
					end else begin
						// Pool exhausted: the add ends here, earlier writes stay.
						res_q.status <= ST_FULL;
						state_q      <= S_OUT;
					end
				end
				S_CLR: begin
					clr_q <= STRIDE'(clr_q + 1'b1);
					if (clr_q == STRIDE'(FANOUT - 1)) begin
						state_q <= S_EVAL;
					end
				end
				S_NODE_RD: begin
					stk_q[lvl_q].leaf <= n_rdata;
					state_q           <= S_EVAL;
				end
				S_EVAL: begin
					if (plen_ext <= depth) begin
						if (!cur.leaf.lf && cur.existed) begin
							stk_q[lvl_q].mode <= MODE_ALL;
							stk_q[lvl_q].i    <= '0;
							state_q           <= S_LOOP;
						end else begin
							state_q <= S_RET;
						end
					end else if (plen_ext < depth + DEPTH_W'(STRIDE)) begin
						stk_q[lvl_q].mode <= MODE_EXP;
						stk_q[lvl_q].i    <= '0;
						state_q           <= S_LOOP;
					end else begin
						stk_q[lvl_q].mode <= MODE_DESC;
						stk_q[lvl_q].i    <= IDX_W'(idx_add);
						state_q           <= S_LOOP;
					end
				end
				S_LOOP: begin
					if (at_end) begin
						state_q <= S_RET;
					end else if (visit) begin
						stk_q[LVL_W'(lvl_q + 1'b1)].plen <= arg_plen;
						stk_q[LVL_W'(lvl_q + 1'b1)].hop  <= arg_hop;
						pslot_q <= {cur.node, cur.i[STRIDE-1:0]};
						// Advance now so that the return needs no look at this frame.
						stk_q[lvl_q].i <= (cur.mode == MODE_DESC) ? IDX_W'(FANOUT) :
							IDX_W'(cur.i + 1'b1);
						state_q <= S_CHILD_RD;
					end else begin
						stk_q[lvl_q].i <= IDX_W'(cur.i + 1'b1);
					end
				end
				S_CHILD_RD: begin
					call_link_q <= c_rdata;
					lvl_q       <= LVL_W'(lvl_q + 1'b1);
					state_q     <= S_CALL;
				end
				S_RET: begin
					if (lvl_q == '0) begin
						res_q.status <= ST_DONE;
						state_q      <= S_OUT;
					end else begin
						lvl_q   <= LVL_W'(lvl_q - 1'b1);
						state_q <= S_LOOP;
					end
				end
				S_LK: begin
					if (lk_stop) begin
						res_q.found        <= hit_q;
						res_q.next_hop_out <= HOP_W'(hhop_q);
						res_q.match_len    <= hlen_q;
						res_q.status       <= ST_DONE;
						state_q            <= S_OUT;
					end else begin
						state_q <= S_LK_RD;
					end
				end
				S_LK_RD: begin
					if (n_rdata.lf) begin
						hit_q  <= 1'b1;
						hhop_q <= n_rdata.hop;
						hlen_q <= n_rdata.len;
					end
					lk_link_q  <= c_rdata;
					lk_depth_q <= DEPTH_W'(lk_depth_q + DEPTH_W'(STRIDE));
					state_q    <= S_LK;
				end
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Leaf record of every node.
	mtrl_ram #(
		.WIDTH($bits(leaf_t)),
		.DEPTH(POOL_NODES)
	) u_node_ram (
		.clk    (clk),
		.wr_en  (n_we),
		.wr_addr(n_waddr),
		.wr_data(n_wdata),
		.rd_en  (n_re),
		.rd_addr(n_raddr),
		.rd_data(n_rdata)
	);

	// Child links, FANOUT per node; zero means no child.
	mtrl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_NODES * FANOUT)
	) u_child_ram (
		.clk    (clk),
		.wr_en  (c_we),
		.wr_addr(c_waddr),
		.wr_data(c_wdata),
		.rd_en  (c_re),
		.rd_addr(c_raddr),
		.rd_data(c_rdata)
	);

`ifndef NO_ASSERTIONS
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pool_q <= LINK_W'(POOL_NODES))
		else $error("node pool count beyond pool size");

	a_link_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALL && call_link_q != '0) |-> (call_link_q <= pool_q))
		else $error("walk follows a link to an unallocated node");

	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q < LVL_W'(LEVELS))
		else $error("insert walk deeper than the frame stack");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request taken while a walk is starting");
`endif

endmodule

// ===== hw/rtl/mtrl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrl_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mtrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
